### src/rsa_pkg.sv
// ----------------------------------------------------------------------------
// rsa_pkg
// Shared widths, request and status codes, and the control/status bundles
// passed between the slot allocator controller and datapath.
// ----------------------------------------------------------------------------
package rsa_pkg;

    // fixed field widths of the request and result transfers
    localparam int CMD_W   = 2;
    localparam int SLOT_W  = 5;
    localparam int STAT_W  = 3;
    localparam int COUNT_W = 6;

    // request codes
    localparam logic [CMD_W-1:0] CMD_PARK     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RETRIEVE = 2'd1;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_ASSIGNED = 3'd0;
    localparam logic [STAT_W-1:0] STAT_NO_FREE  = 3'd1;
    localparam logic [STAT_W-1:0] STAT_RELEASED = 3'd2;
    localparam logic [STAT_W-1:0] STAT_WRONG    = 3'd3;
    localparam logic [STAT_W-1:0] STAT_UNKNOWN  = 3'd4;

    // controller to datapath commands
    typedef struct packed {
        logic load;     // capture request, restart scan
        logic step;     // evaluate one slot of the scan
        logic commit;   // update state and load the result register
    } rsa_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic is_park;    // captured request is a park
        logic scan_last;  // scan sits on the last slot
    } rsa_stat_t;

endpackage

### src/rsa_ctrl.sv
// ----------------------------------------------------------------------------
// rsa_ctrl
// Sequencer for the slot allocator: takes a request, runs the slot scan for
// parks, then commits once the result register is free.
// ----------------------------------------------------------------------------
module rsa_ctrl
    import rsa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  logic      out_stall,
    output rsa_cmd_t  cmd,
    input  rsa_stat_t stat
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_DECODE = 4'b0010,
        ST_SCAN   = 4'b0100,
        ST_DONE   = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    // result register can take a new result
    assign out_free = !out_valid_reg || !out_stall;

    // handshake outputs
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                state_next = stat.is_park ? ST_SCAN : ST_DONE;
            end
            ST_SCAN:
            begin
                cmd.step = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### src/rsa_dp.sv
// ----------------------------------------------------------------------------
// rsa_dp
// Slot allocator datapath: occupancy bits, free count, carousel position,
// the nearest-free-slot scan unit and the result register.
// ----------------------------------------------------------------------------
module rsa_dp
    import rsa_pkg::*;
#(
    parameter int NUM_SLOTS = 6
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [CMD_W-1:0]   command,
    input  logic [SLOT_W-1:0]  slot_id,
    input  rsa_cmd_t           cmd,
    output rsa_stat_t          stat,
    output logic [STAT_W-1:0]  status,
    output logic [SLOT_W-1:0]  slot,
    output logic [COUNT_W-1:0] free_count
);

    localparam int IDX_W = $clog2(NUM_SLOTS);
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);
    localparam logic [CNT_W-1:0] N_CNT = CNT_W'(NUM_SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

    // persistent state
    logic [NUM_SLOTS-1:0] occ_reg;
    logic [NUM_SLOTS-1:0] occ_next;
    logic [CNT_W-1:0]     free_reg;
    logic [CNT_W-1:0]     free_next;
    logic [IDX_W-1:0]     pos_reg;
    logic [IDX_W-1:0]     pos_next;

    // captured request and scan registers
    logic [CMD_W-1:0]     cmd_reg;
    logic [SLOT_W-1:0]    slot_id_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic                 found_reg;
    logic [IDX_W-1:0]     best_reg;
    logic [CNT_W-1:0]     best_dist_reg;

    // result register
    logic [STAT_W-1:0]    status_reg;
    logic [SLOT_W-1:0]    slot_reg;
    logic [COUNT_W-1:0]   free_out_reg;

    logic [CNT_W-1:0]     idx_ext;
    logic [CNT_W-1:0]     pos_ext;
    logic [CNT_W-1:0]     cw;
    logic [CNT_W-1:0]     ccw;
    logic [CNT_W-1:0]     slot_dist;
    logic                 take;
    logic                 id_in_range;
    logic [IDX_W-1:0]     id_idx;
    logic                 id_occupied;
    logic [STAT_W-1:0]    status_next;
    logic [SLOT_W-1:0]    slot_next;

    assign stat.is_park   = (cmd_reg == CMD_PARK);
    assign stat.scan_last = (idx_reg == LAST_IDX);

    // circular distance from the current position to the scanned slot
    always_comb
    begin
        idx_ext = CNT_W'(idx_reg);
        pos_ext = CNT_W'(pos_reg);
        if (idx_ext >= pos_ext)
        begin
            cw = idx_ext - pos_ext;
        end
        else
        begin
            cw = N_CNT - pos_ext + idx_ext;
        end
        ccw       = (cw == '0) ? '0 : (N_CNT - cw);
        slot_dist = (cw < ccw) ? cw : ccw;
        take      = !occ_reg[idx_reg] && (!found_reg || (slot_dist < best_dist_reg));
    end

    // retrieve target check
    assign id_in_range = ({1'b0, slot_id_reg} < (SLOT_W + 1)'(NUM_SLOTS));
    assign id_idx      = slot_id_reg[IDX_W-1:0];
    assign id_occupied = id_in_range && occ_reg[id_idx];

    // state update and result at commit
    always_comb
    begin
        occ_next    = occ_reg;
        free_next   = free_reg;
        pos_next    = pos_reg;
        slot_next   = '0;
        status_next = STAT_UNKNOWN;
        case (cmd_reg)
            CMD_PARK:
            begin
                if (found_reg)
                begin
                    occ_next[best_reg] = 1'b1;
                    if (free_reg != '0)
                    begin
                        free_next = free_reg - 1'b1;
                    end
                    pos_next    = best_reg;
                    slot_next   = SLOT_W'(best_reg);
                    status_next = STAT_ASSIGNED;
                end
                else
                begin
                    status_next = STAT_NO_FREE;
                end
            end
            CMD_RETRIEVE:
            begin
                if (id_occupied)
                begin
                    occ_next[id_idx] = 1'b0;
                    if (free_reg < N_CNT)
                    begin
                        free_next = free_reg + 1'b1;
                    end
                    pos_next    = id_idx;
                    slot_next   = slot_id_reg;
                    status_next = STAT_RELEASED;
                end
                else
                begin
                    status_next = STAT_WRONG;
                end
            end
            default:
            begin
                status_next = STAT_UNKNOWN;
            end
        endcase
    end

    // occupancy, free count and position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg  <= '0;
            free_reg <= N_CNT;
            pos_reg  <= '0;
        end
        else if (cmd.commit)
        begin
            occ_reg  <= occ_next;
            free_reg <= free_next;
            pos_reg  <= pos_next;
        end
    end

    // request capture and scan
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            found_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            idx_reg   <= '0;
            found_reg <= 1'b0;
        end
        else if (cmd.step)
        begin
            if (!stat.scan_last)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (take)
            begin
                found_reg <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg     <= command;
            slot_id_reg <= slot_id;
        end
        if (cmd.step && take)
        begin
            best_reg      <= idx_reg;
            best_dist_reg <= slot_dist;
        end
        if (cmd.commit)
        begin
            status_reg   <= status_next;
            slot_reg     <= slot_next;
            free_out_reg <= COUNT_W'(free_next);
        end
    end

    assign status     = status_reg;
    assign slot       = slot_reg;
    assign free_count = free_out_reg;

endmodule

### src/rotary_slot_allocator_top.sv
// Park: the result is set by the one-slot-per-cycle nearest free slot scan
// over all slots; the next request is taken after the result is committed.
// Retrieve and unknown requests skip the scan and go straight to commit.
// A new request is taken while the previous result still waits downstream.
// Reset (rst_n, async, active low): all slots empty, count NUM_SLOTS, position 0.
// ----------------------------------------------------------------------------
// rotary_slot_allocator_top
// Slot allocator for a rotating carousel: assigns the nearest free slot on a
// park request and frees an occupied slot on a retrieve request.
// ----------------------------------------------------------------------------
module rotary_slot_allocator_top
    import rsa_pkg::*;
#(
    parameter int NUM_SLOTS = 6
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [CMD_W-1:0]   command,
    input  logic [SLOT_W-1:0]  slot_id,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [STAT_W-1:0]  status,
    output logic [SLOT_W-1:0]  slot,
    output logic [COUNT_W-1:0] free_count
);

    rsa_cmd_t  cmd;
    rsa_stat_t stat;

    // sequencer
    rsa_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    // state, scan unit and result register
    rsa_dp #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .command    (command),
        .slot_id    (slot_id),
        .cmd        (cmd),
        .stat       (stat),
        .status     (status),
        .slot       (slot),
        .free_count (free_count)
    );

endmodule

### dv/rotary_slot_allocator_top_test.sv
// ----------------------------------------------------------------------------
// rotary_slot_allocator_top_test
// Self-checking bench for the carousel slot allocator. Park, retrieve and
// unknown requests go in through the valid/stall request channel. A local
// occupancy model predicts each result, and results are checked in order.
// The request channel idles and the result channel stalls at random.
// ----------------------------------------------------------------------------
module rotary_slot_allocator_top_test;

    import rsa_pkg::*;

    localparam int NUM_SLOTS   = 6;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_WAIT  = NUM_SLOTS + 10;

    // request codes the package leaves unnamed
    localparam logic [CMD_W-1:0] CMD_SPARE_2 = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SPARE_3 = 2'd3;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [SLOT_W-1:0]  slot;
        logic [COUNT_W-1:0] free_count;
    } alloc_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [CMD_W-1:0]   command = '0;
    logic [SLOT_W-1:0]  slot_id = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [STAT_W-1:0]  status;
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] free_count;

    // carousel model
    logic [NUM_SLOTS-1:0] bay_taken;
    int unsigned          bays_free;
    int unsigned          carousel_pos;

    alloc_result_t expected_results[$];
    int            error_count = 0;
    int            cycle_count = 0;
    bit            gaps_on = 1'b1;
    bit            stall_on = 1'b1;

    rotary_slot_allocator_top #(
        .NUM_SLOTS(NUM_SLOTS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .command(command),
        .slot_id(slot_id),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .slot(slot),
        .free_count(free_count)
    );

    // clock
    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[rotary_slot_allocator_top] ERROR");
            $finish;
        end
    end

    // apply one request to the model and return its result
    function automatic alloc_result_t predict_allocation(logic [CMD_W-1:0] cmd,
                                                         logic [SLOT_W-1:0] id);
        alloc_result_t res;
        bit            found;
        int unsigned   best;
        int unsigned   best_dist;
        int unsigned   cw;
        int unsigned   ccw;
        int unsigned   arc_dist;
        res = '0;
        found = 1'b0;
        best = 0;
        best_dist = 0;
        if (cmd == CMD_PARK)
        begin
            // nearest free slot either way round, lowest index on a tie
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                if (!bay_taken[i])
                begin
                    cw = (i >= carousel_pos) ? i - carousel_pos : NUM_SLOTS - carousel_pos + i;
                    ccw = (cw == 0) ? 0 : NUM_SLOTS - cw;
                    arc_dist = (cw < ccw) ? cw : ccw;
                    if (!found || arc_dist < best_dist)
                    begin
                        found = 1'b1;
                        best = i;
                        best_dist = arc_dist;
                    end
                end
            end
            if (found)
            begin
                bay_taken[best] = 1'b1;
                if (bays_free > 0)
                    bays_free--;
                carousel_pos = best;
                res.status = STAT_ASSIGNED;
                res.slot = SLOT_W'(best);
            end
            else
                res.status = STAT_NO_FREE;
        end
        else if (cmd == CMD_RETRIEVE)
        begin
            if (id < NUM_SLOTS && bay_taken[id])
            begin
                bay_taken[id] = 1'b0;
                if (bays_free < NUM_SLOTS)
                    bays_free++;
                carousel_pos = id;
                res.status = STAT_RELEASED;
                res.slot = id;
            end
            else
                res.status = STAT_WRONG;
        end
        else
            res.status = STAT_UNKNOWN;
        res.free_count = COUNT_W'(bays_free);
        return res;
    endfunction

    // random idle length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 30);
    endfunction

    // send one request and record its expected result on transfer
    task automatic send_request(logic [CMD_W-1:0] cmd, logic [SLOT_W-1:0] id);
        int gap;
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        slot_id <= id;
        do
            @(posedge clk);
        while (in_stall);
        expected_results.push_back(predict_allocation(cmd, id));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // fill the carousel from reset, then one park too many
    task automatic test_park_until_full();
        for (int i = 0; i <= NUM_SLOTS; i++)
            send_request(CMD_PARK, '0);
    endtask

    // bad and repeated retrieves, unknown requests, a park, then empty the carousel and go past it
    task automatic test_retrieve_cases();
        send_request(CMD_RETRIEVE, 5'd31);
        send_request(CMD_RETRIEVE, SLOT_W'(NUM_SLOTS));
        send_request(CMD_RETRIEVE, 5'd3);
        send_request(CMD_RETRIEVE, 5'd3);
        send_request(CMD_SPARE_2, 5'd31);
        send_request(CMD_SPARE_3, 5'd0);
        send_request(CMD_PARK, 5'd31);
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
            send_request(CMD_RETRIEVE, SLOT_W'(i));
        send_request(CMD_RETRIEVE, 5'd0);
    endtask

    // mostly well-formed parks and retrieves of occupied slots, some noise
    task automatic test_random_traffic(int count);
        int          r;
        int unsigned start;
        int unsigned pick;
        logic [SLOT_W-1:0] id;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                send_request(CMD_PARK, SLOT_W'($urandom_range(0, 31)));
            else if (r < 85)
            begin
                // choose an occupied slot when there is one
                start = $urandom_range(0, NUM_SLOTS - 1);
                id = SLOT_W'($urandom_range(0, 31));
                for (int k = 0; k < NUM_SLOTS; k++)
                begin
                    pick = (start + k) % NUM_SLOTS;
                    if (bay_taken[pick])
                    begin
                        id = SLOT_W'(pick);
                        break;
                    end
                end
                send_request(CMD_RETRIEVE, id);
            end
            else if (r < 95)
                send_request(CMD_RETRIEVE, SLOT_W'($urandom_range(0, 31)));
            else
                send_request(CMD_W'($urandom_range(2, 3)), SLOT_W'($urandom_range(0, 31)));
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        alloc_result_t exp_res;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result status=%0d slot=%0d free_count=%0d",
                         $time, status, slot, free_count);
                error_count++;
            end
            else
            begin
                exp_res = expected_results.pop_front();
                if (status !== exp_res.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp_res.status, status);
                    error_count++;
                end
                if (slot !== exp_res.slot)
                begin
                    $display("%0t: slot expected %0d actual %0d",
                             $time, exp_res.slot, slot);
                    error_count++;
                end
                if (free_count !== exp_res.free_count)
                begin
                    $display("%0t: free_count expected %0d actual %0d",
                             $time, exp_res.free_count, free_count);
                    error_count++;
                end
            end
        end
    end

    // downstream stall: runs of random length, short mostly
    initial
    begin
        int run;
        forever
        begin
            run = ($urandom_range(0, 99) < 75) ? $urandom_range(1, 4) : $urandom_range(5, 40);
            out_stall <= stall_on ? ($urandom_range(0, 2) == 0) : 1'b0;
            repeat (run) @(posedge clk);
        end
    end

    // main sequence
    initial
    begin
        bay_taken = '0;
        bays_free = NUM_SLOTS;
        carousel_pos = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_park_until_full();
        test_retrieve_cases();
        test_random_traffic(1400);

        // back-to-back stretch with no idling on either side
        gaps_on = 1'b0;
        stall_on = 1'b0;
        test_random_traffic(400);

        gaps_on = 1'b1;
        stall_on = 1'b1;
        test_random_traffic(200);

        wait_idle();
        if (error_count == 0)
            $display("[rotary_slot_allocator_top] OK");
        else
            $display("[rotary_slot_allocator_top] ERROR");
        $finish;
    end

endmodule

### sim.f
src/rsa_pkg.sv
src/rsa_ctrl.sv
src/rsa_dp.sv
src/rotary_slot_allocator_top.sv
dv/rotary_slot_allocator_top_test.sv
